/* design/gap_pkg.sv */
package gap_pkg;

    // Field and register widths
    localparam int DIM_W    = 9;
    localparam int AXIS_W   = 2;
    localparam int ADDR_W   = 24;
    localparam int IN_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 9;
    localparam int OUT_W    = 88;

    // Axis codes; the reset map is "xyz"
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;
    // Code that names no axis
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIM_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture sample, permute, advance counters
        logic mul;    // inner multiply-add
        logic fin;    // outer multiply-add into the output register
    } gap_cmd_t;

endpackage

/* design/gap_ctrl.sv */
module gap_ctrl
    import gap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output gap_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Sequencing and output-register occupancy
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul    = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.fin        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // A sample is worked on alone: no second accept right after one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a sample while busy");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");

    // An accepted sample moves on through S_MUL1 to S_MUL2, the output stage
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> ##1 (state_reg == S_MUL2))
        else $error("sequence broken after accept");

    // Every finished result shows up as valid
    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> m_tvalid)
        else $error("result lost");

endmodule

/* design/gap_dpath.sv */
module gap_dpath
    import gap_pkg::*;
#(
    parameter int MAX_DIM     = 256,
    parameter int SAMPLE_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gap_cmd_t             cmd,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [IN_W-1:0]      sample_in,
    output logic [ADDR_W-1:0]    dest_address,
    output logic [IN_W-1:0]      sample_out,
    output logic                 grid_done,
    output logic                 map_error
);

    localparam int CW    = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int CMP_W = 12;
    localparam int PW    = DIM_W + CW;

    // Configuration registers
    logic [DIM_W-1:0]  dim_x_reg, dim_y_reg, dim_z_reg;
    logic [AXIS_W-1:0] axis_x_reg, axis_y_reg, axis_z_reg;

    // Source coordinate counters
    logic [CW-1:0] count_x_reg, count_y_reg, count_z_reg;
    logic [CW-1:0] count_x_next, count_y_next, count_z_next;

    // Captured sample and permuted operands
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [CW-1:0]          px_reg, py_reg, pz_reg;
    logic [DIM_W-1:0]       ddx_reg, ddy_reg;
    logic                   bad_reg, done_reg;
    logic [ADDR_W-1:0]      inner_reg;

    // Output register
    logic [ADDR_W-1:0]      out_addr_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_done_reg, out_err_reg;

    logic [DIM_W-1:0]  dx, dy, dz;
    logic [2:0]        seen;
    logic              bad, lx, ly, lz;
    logic [CW-1:0]     px, py, pz;
    logic [DIM_W-1:0]  ddx, ddy;
    logic [ADDR_W+DIM_W-1:0] outer_prod;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(d) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] pick_c(input logic [AXIS_W-1:0] code,
        input logic [CW-1:0] a, input logic [CW-1:0] b, input logic [CW-1:0] c);
        logic [CW-1:0] r;
        case (code)
            AXIS_X:  r = a;
            AXIS_Y:  r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] pick_d(input logic [AXIS_W-1:0] code,
        input logic [DIM_W-1:0] a, input logic [DIM_W-1:0] b,
        input logic [DIM_W-1:0] c);
        logic [DIM_W-1:0] r;
        case (code)
            AXIS_X:  r = a;
            AXIS_Y:  r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg  <= DIM_W'(1);
            dim_y_reg  <= DIM_W'(1);
            dim_z_reg  <= DIM_W'(1);
            axis_x_reg <= AXIS_X;
            axis_y_reg <= AXIS_Y;
            axis_z_reg <= AXIS_Z;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIM_X:  dim_x_reg  <= cfg_data;
                REG_DIM_Y:  dim_y_reg  <= cfg_data;
                REG_DIM_Z:  dim_z_reg  <= cfg_data;
                REG_AXIS_X: axis_x_reg <= cfg_data[AXIS_W-1:0];
                REG_AXIS_Y: axis_y_reg <= cfg_data[AXIS_W-1:0];
                REG_AXIS_Z: axis_z_reg <= cfg_data[AXIS_W-1:0];
                default:    ;
            endcase
        end
    end

    // Effective dimensions, map check, permutation
    always_comb
    begin
        dx = eff_dim(dim_x_reg);
        dy = eff_dim(dim_y_reg);
        dz = eff_dim(dim_z_reg);
        seen = '0;
        if (axis_x_reg != AXIS_NONE) seen[axis_x_reg] = 1'b1;
        if (axis_y_reg != AXIS_NONE) seen[axis_y_reg] = 1'b1;
        if (axis_z_reg != AXIS_NONE) seen[axis_z_reg] = 1'b1;
        bad = (seen != 3'b111);
        px  = pick_c(axis_x_reg, count_x_reg, count_y_reg, count_z_reg);
        py  = pick_c(axis_y_reg, count_x_reg, count_y_reg, count_z_reg);
        pz  = pick_c(axis_z_reg, count_x_reg, count_y_reg, count_z_reg);
        ddx = pick_d(axis_x_reg, dx, dy, dz);
        ddy = pick_d(axis_y_reg, dx, dy, dz);
    end

    // Raster counter advance; a counter at or past its last index (dimension minus one) wraps
    always_comb
    begin
        lx = (CMP_W'(count_x_reg) + CMP_W'(1)) >= CMP_W'(dx);
        ly = (CMP_W'(count_y_reg) + CMP_W'(1)) >= CMP_W'(dy);
        lz = (CMP_W'(count_z_reg) + CMP_W'(1)) >= CMP_W'(dz);
        count_x_next = count_x_reg;
        count_y_next = count_y_reg;
        count_z_next = count_z_reg;
        if (!lx)
        begin
            count_x_next = count_x_reg + CW'(1);
        end
        else
        begin
            count_x_next = '0;
            if (!ly)
            begin
                count_y_next = count_y_reg + CW'(1);
            end
            else
            begin
                count_y_next = '0;
                count_z_next = lz ? '0 : count_z_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_x_reg <= '0;
            count_y_reg <= '0;
            count_z_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_x_reg <= count_x_next;
            count_y_reg <= count_y_next;
            count_z_reg <= count_z_next;
        end
    end

    // Address arithmetic, taken modulo 2^ADDR_W
    assign outer_prod = (ADDR_W+DIM_W)'(ddx_reg) * (ADDR_W+DIM_W)'(inner_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample_in[SAMPLE_BITS-1:0];
            px_reg     <= px;
            py_reg     <= py;
            pz_reg     <= pz;
            ddx_reg    <= ddx;
            ddy_reg    <= ddy;
            bad_reg    <= bad;
            done_reg   <= lx && ly && lz;
        end
        if (cmd.mul)
        begin
            inner_reg <= ADDR_W'(py_reg) + ADDR_W'(PW'(ddy_reg) * PW'(pz_reg));
        end
        if (cmd.fin)
        begin
            out_addr_reg   <= bad_reg ? '0 : ADDR_W'(px_reg) + outer_prod[ADDR_W-1:0];
            out_sample_reg <= sample_reg;
            out_done_reg   <= done_reg;
            out_err_reg    <= bad_reg;
        end
    end

    assign dest_address = out_addr_reg;
    assign sample_out   = IN_W'(out_sample_reg);
    assign grid_done    = out_done_reg;
    assign map_error    = out_err_reg;

    // The PW-wide inner product is checked against the cast product of the same staged operands
    a_inner_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (PW'(ddy_reg) * PW'(pz_reg)) == PW'(ddy_reg * pz_reg))
        else $error("inner product mismatch");

    // A bad map always yields address zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin && bad_reg) |=> (dest_address == '0) && map_error)
        else $error("bad map produced an address");

    // At the grid's last sample all counters wrap to zero
    a_done_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && lx && ly && lz) |=>
            (count_x_reg == '0) && (count_y_reg == '0) && (count_z_reg == '0))
        else $error("counters not cleared at grid end");

endmodule

/* design/grid_axis_permute_address.sv */
// Axis permutation of a 3-D grid, address side. Samples enter in source raster
// order (x fastest, then y, then z); for each one the block emits the linear
// address of that sample in the grid whose axes are reordered by the
// axis_for_x/y/z registers, plus the sample bits, with tlast on the last sample
// of the grid and tuser set when the axis map is not a permutation (address 0).
// Each sample is handled in steps: one to capture it, permute the coordinates and
// step the counters, then two multiply-add steps (Dy'*z' + y', then
// Dx'*(...) + x') in sequence. The result sits in an output register, so the
// next sample is taken while it waits. Write configuration only when idle;
// it is sampled when a sample is accepted.
module grid_axis_permute_address
    import gap_pkg::*;
#(
    parameter int MAX_DIM     = 256,
    parameter int SAMPLE_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // [63:0] sample_bits
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // [23:0] dest_address, [87:24] sample_out
    output logic                 m_tlast,   // grid_done
    output logic                 m_tuser,   // map_error
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    gap_cmd_t          cmd;
    logic [ADDR_W-1:0] dest_address;
    logic [IN_W-1:0]   sample_out;

    gap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    gap_dpath #(
        .MAX_DIM     (MAX_DIM),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_in    (s_tdata),
        .dest_address (dest_address),
        .sample_out   (sample_out),
        .grid_done    (m_tlast),
        .map_error    (m_tuser)
    );

    assign m_tdata = {sample_out, dest_address};

endmodule
